// ===== hdl/cdan_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdan_pkg;

  // field widths
  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayCntW = 16;
  localparam int unsigned DayW    = 5;
  localparam int unsigned BcdW    = 16;
  localparam int unsigned InW     = 64;
  localparam int unsigned OutW    = 56;

  // calendar constants
  localparam logic [YearW-1:0]   MaxYear       = 14'd9999;
  localparam logic [YearW-1:0]   MinYear       = 14'd1;
  localparam logic [BcdW-1:0]    MaxYearBcd    = 16'h9999;
  localparam logic [MonthW-1:0]  MonthsPerYear = 4'd12;
  localparam logic [MonthW-1:0]  MonthJan      = 4'd1;
  localparam logic [MonthW-1:0]  MonthFeb      = 4'd2;
  localparam logic [MonthW-1:0]  MonthApr      = 4'd4;
  localparam logic [MonthW-1:0]  MonthJun      = 4'd6;
  localparam logic [MonthW-1:0]  MonthSep      = 4'd9;
  localparam logic [MonthW-1:0]  MonthNov      = 4'd11;
  localparam logic [DayW-1:0]    LenLeapFeb    = 5'd29;
  localparam logic [DayW-1:0]    LenFeb        = 5'd28;
  localparam logic [DayW-1:0]    LenShort      = 5'd30;
  localparam logic [DayW-1:0]    LenLong       = 5'd31;

  // sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StWalk,
    StFin
  } state_e;

  // result of one month step of the shared unit
  typedef struct packed {
    logic               fits;
    logic [DayCntW-1:0] day_nx;
    logic [MonthW-1:0]  month_nx;
    logic               wrap;
  } step_t;

  // increment a four digit bcd number
  function automatic logic [BcdW-1:0] bcd_inc(input logic [BcdW-1:0] v);
    logic [BcdW-1:0] r;
    logic            c;
    r = v;
    c = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (c) begin
        if (r[4*i +: 4] == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = r[4*i +: 4] + 4'd1;
          c = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // two digit bcd of a value below 40, tens in the top two bits
  function automatic logic [5:0] bcd2(input logic [DayW-1:0] v);
    logic [1:0]      tens;
    logic [DayW-1:0] ones;
    if (v >= 5'd30) begin
      tens = 2'd3;
      ones = v - 5'd30;
    end else if (v >= 5'd20) begin
      tens = 2'd2;
      ones = v - 5'd20;
    end else if (v >= 5'd10) begin
      tens = 2'd1;
      ones = v - 5'd10;
    end else begin
      tens = 2'd0;
      ones = v;
    end
    return {tens, ones[3:0]};
  endfunction

  // two bcd digits divisible by four
  function automatic logic bcd_div4(input logic [7:0] d);
    logic [1:0] s;
    s = {d[4], 1'b0} + d[1:0];
    return (s == 2'd0);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cdan_bin2bcd.sv =====
`timescale 1ns / 1ps
`default_nettype none

// shift-and-add-3 converter, one year bit per cycle
module cdan_bin2bcd (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [cdan_pkg::YearW-1:0]  bin_i,
  output logic      [cdan_pkg::BcdW-1:0]   bcd_o,
  output logic                             done_o
);

  localparam int unsigned CntW = $clog2(cdan_pkg::YearW);
  localparam logic [CntW-1:0] CntLast = CntW'(cdan_pkg::YearW - 1);

  logic [cdan_pkg::YearW-1:0] bin_q, bin_d;
  logic [cdan_pkg::BcdW-1:0]  bcd_q, bcd_d, adj;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    adj = bcd_q;
    for (int i = 0; i < 4; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  // step control
  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = bin_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {adj[cdan_pkg::BcdW-2:0], bin_q[cdan_pkg::YearW-1]};
      bin_d = {bin_q[cdan_pkg::YearW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign bcd_o  = bcd_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== hdl/cdan_month_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// shared month unit: month length, compare and subtract
module cdan_month_step (
  input  wire logic [cdan_pkg::DayCntW-1:0] day_i,
  input  wire logic [cdan_pkg::MonthW-1:0]  month_i,
  input  wire logic [cdan_pkg::BcdW-1:0]    year_bcd_i,
  output cdan_pkg::step_t                   step_o
);

  logic                    leap;
  logic [cdan_pkg::DayW-1:0] len;

  // leap year from the bcd digits of the year
  always_comb begin
    if (year_bcd_i[7:0] != 8'h00) begin
      leap = cdan_pkg::bcd_div4(year_bcd_i[7:0]);
    end else begin
      leap = cdan_pkg::bcd_div4(year_bcd_i[15:8]);
    end
  end

  // month length
  always_comb begin
    if (month_i == cdan_pkg::MonthFeb) begin
      len = leap ? cdan_pkg::LenLeapFeb : cdan_pkg::LenFeb;
    end else if (month_i == cdan_pkg::MonthApr || month_i == cdan_pkg::MonthJun ||
                 month_i == cdan_pkg::MonthSep || month_i == cdan_pkg::MonthNov) begin
      len = cdan_pkg::LenShort;
    end else begin
      len = cdan_pkg::LenLong;
    end
  end

  // compare, subtract and advance the month
  always_comb begin
    step_o.fits     = (day_i <= cdan_pkg::DayCntW'(len));
    step_o.day_nx   = day_i - cdan_pkg::DayCntW'(len);
    step_o.wrap     = (month_i == cdan_pkg::MonthsPerYear);
    step_o.month_nx = step_o.wrap ? cdan_pkg::MonthJan : month_i + 1'b1;
  end

endmodule

`default_nettype wire

// ===== hdl/calendar_date_add_normalize.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata fields, lowest bit first
// s_axis    in   base_year 14, base_month 4, day_count 16, ref_year 14, ref_month 4,
//                ref_day 5, zero fill 7
// m_axis    out  out_year 14, out_month 4, out_day 5, year_digits 16, month_digits 5,
//                day_digits 6, later_than_ref 1, year_overflow 1, zero fill 4
//
// the result word is valid once the year conversion, the month walk through the shared
// month unit and the finish step are done after acceptance
// the year is turned into bcd first, one bit per cycle, and kept in bcd during the walk;
// a base year past the last one skips the walk and goes from the conversion to the finish step
// reset clears the sequencer and the output valid; no clearing pass
// tready returns the cycle after the result word is loaded; a stalled master side holds
// only the finish step, so the next word may already be walking
module calendar_date_add_normalize (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [cdan_pkg::InW-1:0]    s_axis_tdata,  // base_year, base_month,
                                                          // day_count, ref_year,
                                                          // ref_month, ref_day
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic      [cdan_pkg::OutW-1:0]   m_axis_tdata   // out_year, out_month, out_day,
                                                          // year_digits, month_digits,
                                                          // day_digits, later_than_ref,
                                                          // year_overflow
);

  cdan_pkg::state_e state_q, state_d;

  logic [cdan_pkg::YearW-1:0]   year_q, year_d;
  logic [cdan_pkg::BcdW-1:0]    ybcd_q, ybcd_d;
  logic [cdan_pkg::MonthW-1:0]  month_q, month_d;
  logic [cdan_pkg::DayCntW-1:0] day_q, day_d;
  logic [cdan_pkg::YearW-1:0]   ry_q, ry_d;
  logic [cdan_pkg::MonthW-1:0]  rm_q, rm_d;
  logic [cdan_pkg::DayW-1:0]    rd_q, rd_d;
  logic                         ovf_q, ovf_d;
  logic                         ovalid_q, ovalid_d;
  logic [cdan_pkg::OutW-1:0]    odata_q, odata_d;

  // input fields
  logic [cdan_pkg::YearW-1:0]   in_year;
  logic [cdan_pkg::MonthW-1:0]  in_month;
  logic [cdan_pkg::DayCntW-1:0] in_day;
  logic [cdan_pkg::YearW-1:0]   yr_clamp;
  logic [cdan_pkg::MonthW-1:0]  mo_clamp;
  logic                         in_big;

  logic                         accept;
  logic                         conv_done;
  logic [cdan_pkg::BcdW-1:0]    conv_bcd;
  cdan_pkg::step_t              step;

  logic                         later;
  logic [cdan_pkg::DayW-1:0]    day5;
  logic [5:0]                   day_bcd;
  logic [5:0]                   month_bcd;

  assign in_year  = s_axis_tdata[13:0];
  assign in_month = s_axis_tdata[17:14];
  assign in_day   = s_axis_tdata[33:18];

  // range fixes on the base date
  always_comb begin
    in_big   = (in_year > cdan_pkg::MaxYear);
    yr_clamp = in_year;
    if (in_year == '0) begin
      yr_clamp = cdan_pkg::MinYear;
    end else if (in_big) begin
      yr_clamp = cdan_pkg::MaxYear;
    end
    mo_clamp = in_month;
    if (in_month == '0 || in_month > cdan_pkg::MonthsPerYear) begin
      mo_clamp = cdan_pkg::MonthJan;
    end
    if (in_big) begin
      mo_clamp = cdan_pkg::MonthsPerYear;
    end
  end

  assign s_axis_tready = (state_q == cdan_pkg::StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;

  cdan_bin2bcd u_bin2bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .bin_i   (yr_clamp),
    .bcd_o   (conv_bcd),
    .done_o  (conv_done)
  );

  cdan_month_step u_month_step (
    .day_i      (day_q),
    .month_i    (month_q),
    .year_bcd_i (ybcd_q),
    .step_o     (step)
  );

  // compare with the reference date and pack the result word
  assign day5      = day_q[cdan_pkg::DayW-1:0];
  assign day_bcd   = cdan_pkg::bcd2(day5);
  assign month_bcd = cdan_pkg::bcd2(cdan_pkg::DayW'(month_q));

  always_comb begin
    later = (year_q > ry_q) ||
            (year_q == ry_q && month_q > rm_q) ||
            (year_q == ry_q && month_q == rm_q && day5 > rd_q);
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    year_d   = year_q;
    ybcd_d   = ybcd_q;
    month_d  = month_q;
    day_d    = day_q;
    ry_d     = ry_q;
    rm_d     = rm_q;
    rd_d     = rd_q;
    ovf_d    = ovf_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;

    // output register drains independently
    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      cdan_pkg::StIdle: begin
        if (accept) begin
          year_d  = yr_clamp;
          month_d = mo_clamp;
          day_d   = in_big ? cdan_pkg::DayCntW'(cdan_pkg::LenLong) : in_day;
          ovf_d   = in_big;
          ry_d    = s_axis_tdata[47:34];
          rm_d    = s_axis_tdata[51:48];
          rd_d    = s_axis_tdata[56:52];
          state_d = cdan_pkg::StConv;
        end
      end
      cdan_pkg::StConv: begin
        if (conv_done) begin
          ybcd_d  = conv_bcd;
          state_d = ovf_q ? cdan_pkg::StFin : cdan_pkg::StWalk;
        end
      end
      cdan_pkg::StWalk: begin
        if (step.fits) begin
          state_d = cdan_pkg::StFin;
        end else begin
          day_d   = step.day_nx;
          month_d = step.month_nx;
          if (step.wrap) begin
            if (year_q >= cdan_pkg::MaxYear) begin
              // rolled past the last representable year
              year_d  = cdan_pkg::MaxYear;
              ybcd_d  = cdan_pkg::MaxYearBcd;
              month_d = cdan_pkg::MonthsPerYear;
              day_d   = cdan_pkg::DayCntW'(cdan_pkg::LenLong);
              ovf_d   = 1'b1;
              state_d = cdan_pkg::StFin;
            end else begin
              year_d = year_q + 1'b1;
              ybcd_d = cdan_pkg::bcd_inc(ybcd_q);
            end
          end
        end
      end
      cdan_pkg::StFin: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = {4'b0, ovf_q, later, day_bcd, month_bcd[4:0], ybcd_q,
                      day5, month_q, year_q};
          state_d  = cdan_pkg::StIdle;
        end
      end
      default: begin
        state_d = cdan_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cdan_pkg::StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk_i) begin
    year_q  <= year_d;
    ybcd_q  <= ybcd_d;
    month_q <= month_d;
    day_q   <= day_d;
    ry_q    <= ry_d;
    rm_q    <= rm_d;
    rd_q    <= rd_d;
    ovf_q   <= ovf_d;
    odata_q <= odata_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule

`default_nettype wire

// ===== bench/date_add_checker.sv =====
`timescale 1ns / 1ps

// watches both channels, predicts each normalized date and compares the result words
module date_add_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  input  logic                      s_tready_i,
  input  logic [cdan_pkg::InW-1:0]  s_tdata_i,   // base_year, base_month, day_count,
                                                 // ref_year, ref_month, ref_day
  input  logic                      m_tvalid_i,
  input  logic                      m_tready_i,
  input  logic [cdan_pkg::OutW-1:0] m_tdata_i,   // out_year, out_month, out_day,
                                                 // year_digits, month_digits,
                                                 // day_digits, later_than_ref,
                                                 // year_overflow
  output int                        fail_cnt_o,
  output int                        pending_cnt_o,
  output int                        checked_cnt_o,
  output int                        ovf_cnt_o,
  output int                        later_cnt_o
);

  typedef struct packed {
    logic [cdan_pkg::YearW-1:0]  year;
    logic [cdan_pkg::MonthW-1:0] month;
    logic [cdan_pkg::DayW-1:0]   day;
    logic [cdan_pkg::BcdW-1:0]   year_bcd;
    logic [4:0]                  month_bcd;
    logic [5:0]                  day_bcd;
    logic                        later;
    logic                        ovf;
  } date_res_t;

  date_res_t expected_dates[$];
  logic      field_err;

  // four bcd digits, lowest digit in the low nibble
  function automatic logic [cdan_pkg::BcdW-1:0] bcd_of(input int unsigned v);
    logic [cdan_pkg::BcdW-1:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      r[4*i +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return r;
  endfunction

  // walk the day count forward month by month until it fits
  function automatic date_res_t normalize_date(input logic [cdan_pkg::InW-1:0] w);
    int unsigned               yr, mo, dc, ry, rm, rd, len;
    logic                      ovf, done, leap;
    logic [cdan_pkg::BcdW-1:0] mo_bcd, dc_bcd;
    date_res_t                 r;
    yr  = 32'(w[13:0]);
    mo  = 32'(w[17:14]);
    dc  = 32'(w[33:18]);
    ry  = 32'(w[47:34]);
    rm  = 32'(w[51:48]);
    rd  = 32'(w[56:52]);
    ovf = 1'b0;
    if (mo < cdan_pkg::MonthJan || mo > cdan_pkg::MonthsPerYear) mo = 32'(cdan_pkg::MonthJan);
    if (yr == 0) yr = 32'(cdan_pkg::MinYear);
    // a base year past the last one saturates at once
    if (yr > cdan_pkg::MaxYear) begin
      yr  = 32'(cdan_pkg::MaxYear);
      mo  = 32'(cdan_pkg::MonthsPerYear);
      dc  = 32'(cdan_pkg::LenLong);
      ovf = 1'b1;
    end
    done = ovf;
    while (!done) begin
      leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      if (mo == cdan_pkg::MonthFeb) begin
        len = leap ? 32'(cdan_pkg::LenLeapFeb) : 32'(cdan_pkg::LenFeb);
      end else if (mo == cdan_pkg::MonthApr || mo == cdan_pkg::MonthJun ||
                   mo == cdan_pkg::MonthSep || mo == cdan_pkg::MonthNov) begin
        len = 32'(cdan_pkg::LenShort);
      end else begin
        len = 32'(cdan_pkg::LenLong);
      end
      if (dc <= len) begin
        done = 1'b1;
      end else begin
        dc = dc - len;
        mo = mo + 1;
        // december rolls into the next year, or saturates after the last year
        if (mo > cdan_pkg::MonthsPerYear) begin
          mo = 32'(cdan_pkg::MonthJan);
          if (yr >= cdan_pkg::MaxYear) begin
            yr   = 32'(cdan_pkg::MaxYear);
            mo   = 32'(cdan_pkg::MonthsPerYear);
            dc   = 32'(cdan_pkg::LenLong);
            ovf  = 1'b1;
            done = 1'b1;
          end else begin
            yr = yr + 1;
          end
        end
      end
    end
    mo_bcd      = bcd_of(mo);
    dc_bcd      = bcd_of(dc);
    r.year      = cdan_pkg::YearW'(yr);
    r.month     = cdan_pkg::MonthW'(mo);
    r.day       = cdan_pkg::DayW'(dc);
    r.year_bcd  = bcd_of(yr);
    r.month_bcd = mo_bcd[4:0];
    r.day_bcd   = dc_bcd[5:0];
    r.later     = (yr > ry) || (yr == ry && mo > rm) || (yr == ry && mo == rm && dc > rd);
    r.ovf       = ovf;
    return r;
  endfunction

  // one field of a result word against the prediction
  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
      field_err = 1'b1;
    end
  endtask

  // compare accepted results first, then queue the prediction for a new word
  always @(posedge clk_i or negedge rst_ni) begin
    date_res_t want;
    if (!rst_ni) begin
      fail_cnt_o    <= 0;
      pending_cnt_o <= 0;
      checked_cnt_o <= 0;
      ovf_cnt_o     <= 0;
      later_cnt_o   <= 0;
      expected_dates.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: result word 'h%0h with nothing expected", $time, m_tdata_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want      = expected_dates.pop_front();
          field_err = 1'b0;
          check_field("out_year", want.year, m_tdata_i[13:0]);
          check_field("out_month", want.month, m_tdata_i[17:14]);
          check_field("out_day", want.day, m_tdata_i[22:18]);
          check_field("year_digits", want.year_bcd, m_tdata_i[38:23]);
          check_field("month_digits", want.month_bcd, m_tdata_i[43:39]);
          check_field("day_digits", want.day_bcd, m_tdata_i[49:44]);
          check_field("later_than_ref", want.later, m_tdata_i[50]);
          check_field("year_overflow", want.ovf, m_tdata_i[51]);
          if (field_err) fail_cnt_o <= fail_cnt_o + 1;
          checked_cnt_o <= checked_cnt_o + 1;
          if (want.ovf) ovf_cnt_o <= ovf_cnt_o + 1;
          if (want.later) later_cnt_o <= later_cnt_o + 1;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_dates.push_back(normalize_date(s_tdata_i));
      end
      pending_cnt_o <= expected_dates.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RandItems  = 250;
  localparam int unsigned CycleLimit = 3_000_000;

  typedef enum int unsigned {
    RdyOpen,
    RdyCoin,
    RdySparse,
    RdyPulse
  } rdy_mode_e;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [cdan_pkg::InW-1:0]  s_axis_tdata  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [cdan_pkg::OutW-1:0] m_axis_tdata;

  int fail_cnt, pending_cnt, checked_cnt, ovf_cnt, later_cnt;
  int unsigned cycle_cnt  = 0;
  int unsigned burst_left = 0;
  int unsigned sent_cnt   = 0;
  int unsigned directed_cnt;

  calendar_date_add_normalize u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  date_add_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt),
    .checked_cnt_o (checked_cnt),
    .ovf_cnt_o     (ovf_cnt),
    .later_cnt_o   (later_cnt)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_cnt, pending_cnt);
      $display("[calendar_date_add_normalize] ERROR");
      $finish;
    end
  end

  // receiver stalls, switching between patterns every so often
  rdy_mode_e   ready_mode = RdyOpen;
  int unsigned mode_left  = 0;
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = rdy_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(16, 200);
    end
    mode_left = mode_left - 1;
    case (ready_mode)
      RdyOpen:   m_axis_tready = 1'b1;
      RdyCoin:   m_axis_tready = 1'($urandom_range(0, 1));
      RdySparse: m_axis_tready = ($urandom_range(0, 7) == 0);
      default:   m_axis_tready = (mode_left % 8) < 3;
    endcase
  end

  // pack one input word, base_year in the low bits
  function automatic logic [cdan_pkg::InW-1:0] date_word(
    input logic [13:0] yr, input logic [3:0] mo, input logic [15:0] dc,
    input logic [13:0] ry, input logic [3:0] rm, input logic [4:0] rd
  );
    return {7'd0, rd, rm, ry, dc, mo, yr};
  endfunction

  // offer one word in bursts with random gaps; called and left at a falling edge
  task automatic offer_item(input logic [cdan_pkg::InW-1:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left    = burst_left - 1;
    s_axis_tdata  = w;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    sent_cnt = sent_cnt + 1;
  endtask

  // hold the sender until every result is back
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [13:0] yr, ry;
    logic [3:0]  mo, rm;
    logic [15:0] dc;
    logic [4:0]  rd;
    int unsigned pick;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zero count, leap rules, wraps, out of range fields, saturation
    offer_item(date_word(14'd2024, 4'd1, 16'd0, 14'd2024, 4'd1, 5'd0));
    offer_item(date_word(14'd2024, 4'd2, 16'd29, 14'd2024, 4'd2, 5'd28));
    offer_item(date_word(14'd2023, 4'd2, 16'd29, 14'd2023, 4'd3, 5'd1));
    offer_item(date_word(14'd1900, 4'd2, 16'd29, 14'd1900, 4'd3, 5'd2));
    offer_item(date_word(14'd2000, 4'd2, 16'd29, 14'd2000, 4'd2, 5'd29));
    offer_item(date_word(14'd2023, 4'd12, 16'd32, 14'd2023, 4'd12, 5'd31));
    offer_item(date_word(14'd2023, 4'd4, 16'd31, 14'd2023, 4'd5, 5'd1));
    offer_item(date_word(14'd1999, 4'd0, 16'd40, 14'd0, 4'd0, 5'd0));
    offer_item(date_word(14'd1999, 4'd13, 16'd10, 14'd1999, 4'd1, 5'd9));
    offer_item(date_word(14'd1999, 4'd15, 16'd1, 14'd1999, 4'd15, 5'd31));
    offer_item(date_word(14'd0, 4'd1, 16'd5, 14'd1, 4'd1, 5'd4));
    offer_item(date_word(14'd0, 4'd0, 16'd0, 14'd0, 4'd0, 5'd0));
    offer_item(date_word(14'd10000, 4'd3, 16'd3, 14'd9999, 4'd12, 5'd30));
    offer_item(date_word(14'd16383, 4'd15, 16'd65535, 14'd16383, 4'd15, 5'd31));
    offer_item(date_word(14'd9999, 4'd12, 16'd31, 14'd9999, 4'd12, 5'd31));
    offer_item(date_word(14'd9999, 4'd12, 16'd32, 14'd9999, 4'd12, 5'd30));
    offer_item(date_word(14'd9990, 4'd1, 16'd65535, 14'd9990, 4'd1, 5'd1));
    offer_item(date_word(14'd1, 4'd1, 16'd65535, 14'd180, 4'd6, 5'd15));
    offer_item(date_word(14'd1, 4'd1, 16'd1, 14'd1, 4'd1, 5'd1));
    offer_item(date_word(14'd2100, 4'd2, 16'd366, 14'd2101, 4'd2, 5'd1));
    offer_item(date_word(14'd2400, 4'd1, 16'd60, 14'd2400, 4'd2, 5'd29));
    offer_item(date_word(14'd5000, 4'd6, 16'd30, 14'd5000, 4'd6, 5'd29));
    offer_item(date_word(14'd5000, 4'd6, 16'd30, 14'd4999, 4'd12, 5'd31));
    offer_item(date_word(14'd8191, 4'd8, 16'd32768, 14'd8192, 4'd8, 5'd16));
    directed_cnt = sent_cnt;
    wait_drained();

    // random: mostly short walks, some full range counts and years near the end
    for (int n = 0; n < RandItems; n++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) yr = 14'd0;
      else if (pick <= 2) yr = 14'($urandom_range(0, 16383));
      else if (pick <= 4) yr = 14'($urandom_range(9990, 9999));
      else yr = 14'($urandom_range(1, 9999));
      mo = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 12));
      pick = $urandom_range(0, 19);
      if (pick <= 2) dc = 16'($urandom_range(0, 65535));
      else if (pick <= 6) dc = 16'($urandom_range(0, 400));
      else dc = 16'($urandom_range(0, 62));
      // reference near the base date half the time so the comparison flips
      if ($urandom_range(0, 1) == 0) begin
        ry = yr + 14'($urandom_range(0, 1));
        rm = ($urandom_range(0, 1) == 0) ? mo : 4'($urandom_range(1, 12));
      end else begin
        ry = 14'($urandom_range(0, 16383));
        rm = 4'($urandom_range(0, 15));
      end
      rd = 5'($urandom_range(0, 31));
      offer_item(date_word(yr, mo, dc, ry, rm, rd));
      if (n == RandItems / 2) wait_drained();
    end

    wait_drained();
    repeat (40) @(negedge clk_i);

    $display("sent %0d dates (%0d directed), %0d results checked", sent_cnt, directed_cnt,
             checked_cnt);
    $display("%0d saturated past the last year, %0d fell after their reference date",
             ovf_cnt, later_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("[calendar_date_add_normalize] OK");
    end else begin
      $display("[calendar_date_add_normalize] ERROR");
    end
    $finish;
  end

endmodule
